// File: sv/mbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg
// shared constants and controller/datapath interface types of the
// escape-time unit
// ----------------------------------------------------------------------------
package mbe_pkg;

  // default geometry
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 28;
  localparam int COUNT_WIDTH_DEF = 16;

  // hue output
  localparam int HUE_WIDTH = 9;
  localparam int HUE_SPAN  = 360;

  // iteration limit after reset
  localparam int LIMIT_RESET = 400;

  // escape test is |z|^2 >= radius squared
  localparam int ESC_RADIUS_SQ = 4;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // take a new point, clear z and count
    logic mul;        // register the three products
    logic step;       // write back the next z, bump count
    logic div_start;  // launch hue division
    logic out_load;   // move the finished result to the output register
  } mbe_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic escape;     // |z|^2 at or above bound
    logic at_limit;   // count has reached the limit
    logic in_set;     // count equals the limit
    logic div_busy;   // hue division running
  } mbe_sts_t;

endpackage

// File: sv/mbe_hue_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_hue_div
// restoring divider for floor(count * 360 / limit), one quotient bit a cycle
// ----------------------------------------------------------------------------
module mbe_hue_div #(
  parameter int COUNT_WIDTH = mbe_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [COUNT_WIDTH-1:0]         count,
  input  logic [COUNT_WIDTH-1:0]         limit,
  output logic                           busy,
  output logic [mbe_pkg::HUE_WIDTH-1:0]  quo
);
  import mbe_pkg::*;

  localparam int NUM_W = COUNT_WIDTH + HUE_WIDTH;
  localparam int STP_W = $clog2(HUE_WIDTH + 1);

  logic                 busy_r;
  logic [STP_W-1:0]     step_r;
  logic [NUM_W-1:0]     rem_r;
  logic [NUM_W-1:0]     den_r;
  logic [HUE_WIDTH-1:0] quo_r;
  logic                 fits;

  // quotient stays below 2^HUE_WIDTH since count < limit
  assign fits = (rem_r >= den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + STP_W'(1);
      if (step_r == STP_W'(HUE_WIDTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= NUM_W'(count) * NUM_W'(HUE_SPAN);
      den_r <= NUM_W'(limit) << (HUE_WIDTH - 1);
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - den_r;
      end
      den_r <= den_r >> 1;
      quo_r <= {quo_r[HUE_WIDTH-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

`ifndef SYNTHESIS
  // a finished division never gives a hue of a full turn or more
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> (quo_r < HUE_WIDTH'(HUE_SPAN)))
    else $error("hue quotient out of range");
`endif

endmodule

// File: sv/mbe_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_dp
// datapath: point and z registers, product stage, escape test, z update,
// iteration count, limit register, hue divider and output register
// ----------------------------------------------------------------------------
module mbe_dp #(
  parameter int COORD_WIDTH = mbe_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = mbe_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = mbe_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [COUNT_WIDTH-1:0]         cfg_wr_data,
  input  logic signed [COORD_WIDTH-2:0]  c_re,
  input  logic signed [COORD_WIDTH-2:0]  c_im,
  input  mbe_pkg::mbe_cmd_t              cmd,
  output mbe_pkg::mbe_sts_t              sts,
  output logic [COUNT_WIDTH-1:0]         out_count,
  output logic                           out_inside,
  output logic [mbe_pkg::HUE_WIDTH-1:0]  out_hue
);
  import mbe_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int IW = COORD_WIDTH - 1;
  localparam int PW = 2 * COORD_WIDTH;
  localparam logic [PW-1:0] ESC_BOUND = PW'(ESC_RADIUS_SQ) << (2 * FRAC_BITS);

  logic [COUNT_WIDTH-1:0] limit_r;
  logic signed [IW-1:0]   cr_r;
  logic signed [IW-1:0]   ci_r;
  logic signed [CW-1:0]   zr_r;
  logic signed [CW-1:0]   zi_r;
  logic signed [PW-1:0]   sr_r;
  logic signed [PW-1:0]   si_r;
  logic signed [PW-1:0]   sx_r;
  logic [COUNT_WIDTH-1:0] count_r;
  logic signed [PW-1:0]   re_acc;
  logic signed [PW-1:0]   im_acc;
  logic [PW-1:0]          sq_sum;
  logic signed [CW-1:0]   zr_nxt;
  logic signed [CW-1:0]   zi_nxt;
  logic                   div_busy;
  logic [HUE_WIDTH-1:0]   div_quo;
  logic [COUNT_WIDTH-1:0] out_count_r;
  logic                   out_inside_r;
  logic [HUE_WIDTH-1:0]   out_hue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= COUNT_WIDTH'(LIMIT_RESET);
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // floor rounding comes from the arithmetic shift
  assign re_acc = ((sr_r - si_r) >>> FRAC_BITS) + PW'(cr_r);
  assign im_acc = ((sx_r <<< 1) >>> FRAC_BITS) + PW'(ci_r);
  assign zr_nxt = re_acc[CW-1:0];
  assign zi_nxt = im_acc[CW-1:0];

  // both squares are non-negative, so the unsigned sum cannot wrap
  assign sq_sum = $unsigned(sr_r) + $unsigned(si_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr_r    <= c_re;
      ci_r    <= c_im;
      zr_r    <= '0;
      zi_r    <= '0;
      count_r <= '0;
    end else if (cmd.step) begin
      zr_r    <= zr_nxt;
      zi_r    <= zi_nxt;
      count_r <= count_r + COUNT_WIDTH'(1);
    end
    if (cmd.mul) begin
      sr_r <= zr_r * zr_r;
      si_r <= zi_r * zi_r;
      sx_r <= zr_r * zi_r;
    end
  end

  mbe_hue_div #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_hue_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .count (count_r),
    .limit (limit_r),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  always_comb begin
    sts.escape   = (sq_sum >= ESC_BOUND);
    sts.at_limit = (count_r >= limit_r);
    sts.in_set   = (count_r == limit_r);
    sts.div_busy = div_busy;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count_r  <= count_r;
      out_inside_r <= sts.in_set;
      out_hue_r    <= sts.in_set ? '0 : div_quo;
    end
  end

  assign out_count  = out_count_r;
  assign out_inside = out_inside_r;
  assign out_hue    = out_hue_r;

`ifndef SYNTHESIS
  // no step past the limit
  a_step_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (count_r < limit_r))
    else $error("iteration step at or beyond limit");

  // the divider only runs for escaped points
  a_div_escaped: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (!sts.in_set && !div_busy))
    else $error("hue division started for inside point or while busy");
`endif

endmodule

// File: sv/mbe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_ctrl
// sequencer: accept, product/check loop, hue division, result hand-off
// ----------------------------------------------------------------------------
module mbe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  mbe_pkg::mbe_sts_t  sts,
  output mbe_pkg::mbe_cmd_t  cmd
);
  import mbe_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_CHK  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (sts.escape || sts.at_limit) begin
          if (sts.in_set) begin
            state_nxt = ST_DONE;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV;
          end
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

`ifndef SYNTHESIS
  // the output register is only overwritten once its transaction is done
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten before transaction");
`endif

endmodule

// File: sv/mandelbrot_escape_time_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top
// escape-time iteration of z = z*z + c from zero with iteration count,
// inside flag and hue as floor(count * 360 / limit)
// ----------------------------------------------------------------------------
//
// channel | dir | transaction contents
// --------+-----+-----------------------------------------------------------
// in_*    | in  | one point: tdata = {c_im, c_re}
// out_*   | out | one result: tdata = {hue_deg, iter_count}, tuser = inside_res
// cfg_*   | in  | write of max_iterations, taken on any edge with cfg_wr_en
//
// each point runs the product/check loop; an escaped point also passes
//   through the bit-serial hue divider (one quotient bit per cycle)
// each loop pass uses the shared product stage: the MUL state registers the
//   three products, the CHK state does the escape test and z update
// one point at a time; a new point is taken while the last result still
//   waits in the output register
// reset (rst_n low, synchronous) empties the unit and sets the limit to 400
// a stalled output holds the result and the unit waits before the hand-off
//
module mandelbrot_escape_time_top #(
  parameter int COORD_WIDTH = mbe_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = mbe_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = mbe_pkg::COUNT_WIDTH_DEF,
  localparam int IN_DATA_W  = ((2 * (COORD_WIDTH - 1) + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((COUNT_WIDTH + mbe_pkg::HUE_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_wr_en,
  input  logic [COUNT_WIDTH-1:0] cfg_wr_data,   // max_iterations
  // point stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,      // c_re, c_im (lowest first)
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,     // iter_count, hue_deg (lowest first)
  output logic                   out_tuser      // inside_res
);
  import mbe_pkg::*;

  localparam int IW = COORD_WIDTH - 1;

  mbe_cmd_t               cmd;
  mbe_sts_t               sts;
  logic signed [IW-1:0]   c_re;
  logic signed [IW-1:0]   c_im;
  logic [COUNT_WIDTH-1:0] res_count;
  logic                   res_inside;
  logic [HUE_WIDTH-1:0]   res_hue;

  // unpack the point; padding bits above the two fields are ignored
  assign c_re = in_tdata[IW-1:0];
  assign c_im = in_tdata[2*IW-1:IW];

  mbe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mbe_dp #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .c_re        (c_re),
    .c_im        (c_im),
    .cmd         (cmd),
    .sts         (sts),
    .out_count   (res_count),
    .out_inside  (res_inside),
    .out_hue     (res_hue)
  );

  // pack the result, zero-filled to whole bytes
  assign out_tdata = OUT_DATA_W'({res_hue, res_count});
  assign out_tuser = res_inside;

endmodule

// File: tb/mandelbrot_escape_time_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top_tb
// self-checking bench for the escape-time unit: points in on the input
// stream, each result checked against an in-bench escape iteration with the
// same fixed-point rules, limit changed between phases while the unit is
// idle, both stream sides idle at random
// ----------------------------------------------------------------------------

typedef struct {
  logic [15:0] iter_count;
  logic        in_set;
  logic [8:0]  hue_deg;
} escape_result_t;

class escape_scoreboard;
  escape_result_t expected_escapes[$];
  int points_seen;
  int results_seen;
  int inside_seen;
  int mismatches;

  function new();
    points_seen  = 0;
    results_seen = 0;
    inside_seen  = 0;
    mismatches   = 0;
  endfunction

  // z = z*z + c from zero, full 64-bit squares, floor shift, limit test last
  function escape_result_t predict_escape(logic signed [30:0] c_re,
                                          logic signed [30:0] c_im,
                                          int unsigned limit);
    longint signed   cr, ci, zr, zi, sq_re, sq_im, nr, ni;
    longint unsigned bound;
    int unsigned     steps;
    escape_result_t  r;
    cr    = c_re;
    ci    = c_im;
    zr    = 0;
    zi    = 0;
    steps = 0;
    bound = longint'(mbe_pkg::ESC_RADIUS_SQ) << (2 * mbe_pkg::FRAC_BITS_DEF);
    forever begin
      sq_re = zr * zr;
      sq_im = zi * zi;
      if (longint'(unsigned'(sq_re)) + longint'(unsigned'(sq_im)) < 0) break;
      if ($unsigned(sq_re) + $unsigned(sq_im) >= bound) break;
      if (steps >= limit) break;
      nr = ((sq_re - sq_im) >>> mbe_pkg::FRAC_BITS_DEF) + cr;
      ni = ((2 * (zr * zi)) >>> mbe_pkg::FRAC_BITS_DEF) + ci;
      zr = nr;
      zi = ni;
      steps++;
    end
    r.iter_count = steps[15:0];
    r.in_set     = (steps == limit);
    r.hue_deg    = 9'd0;
    if (!r.in_set && limit != 0)
      r.hue_deg = 9'((longint'(steps) * mbe_pkg::HUE_SPAN) / limit);
    return r;
  endfunction

  function void note_point(logic signed [30:0] c_re, logic signed [30:0] c_im,
                           int unsigned limit);
    escape_result_t r;
    r = predict_escape(c_re, c_im, limit);
    expected_escapes.push_back(r);
    points_seen++;
    if (r.in_set) inside_seen++;
  endfunction

  task report(string field, longint got, longint want);
    $display("mismatch on result %0d: %s is %0d, expected %0d",
             results_seen, field, got, want);
    mismatches++;
  endtask

  task check_result(logic [15:0] iter_count, logic inside_res, logic [8:0] hue_deg);
    escape_result_t want;
    results_seen++;
    if (expected_escapes.size() == 0) begin
      report("unexpected result, iter_count", iter_count, -1);
    end else begin
      want = expected_escapes.pop_front();
      if (iter_count !== want.iter_count) report("iter_count", iter_count, want.iter_count);
      if (inside_res !== want.in_set) report("inside_res", inside_res, want.in_set);
      if (hue_deg !== want.hue_deg) report("hue_deg", hue_deg, want.hue_deg);
    end
  endtask
endclass

module mandelbrot_escape_time_top_tb;

  // Q4.28 constants
  localparam int Q_ONE   = 268435456;
  localparam int C_MAX   = 1073741823;
  localparam int C_MIN   = -1073741824;
  localparam int Q_QUART = 67108864;     // 0.25, cusp of the main cardioid
  localparam int Q_026   = 69793218;     // 0.26, just outside the cusp, slow escape
  localparam int Q_TENTH = 26843545;     // 0.1
  localparam int Q_NECK  = -201326592;   // -0.75, neck between bulbs

  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 138;
  localparam int SETTLE_CYCLES   = 20;     // unit has no pending work once results are in
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 5000000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;      // c_re [30:0], c_im [61:31], zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;     // iter_count [15:0], hue_deg [24:16], zero pad
  logic        out_tuser;     // inside_res

  escape_scoreboard sb = new();

  int unsigned cur_limit;     // limit the unit holds, tracked by the bench
  int          limit_settings;
  bit          no_idle;       // phases with back-to-back transactions on both sides
  int          stall_left;
  longint      cycle_count = 0;

  mandelbrot_escape_time_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // hard stop in case the unit hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, sb.expected_escapes.size());
      $display("simulation failed");
      $finish;
    end
  end

  // result side: after each transaction draw how long ready stays low
  always @(posedge clk) begin : ready_gen
    int stall_draw;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (out_tvalid && out_tready) begin
      stall_draw = no_idle ? 0 : $urandom_range(0, 5);
      out_tready <= (stall_draw == 0);
      stall_left <= stall_draw;
    end else if (!out_tready) begin
      if (stall_left <= 1) out_tready <= 1'b1;
      stall_left <= (stall_left == 0) ? 0 : stall_left - 1;
    end
  end

  // result monitor: every accepted transaction goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[15:0], out_tuser, out_tdata[24:16]);
  end

  // one point transaction; valid stays high when the next gap is zero
  task send_point(input logic signed [30:0] c_re, input logic signed [30:0] c_im);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, c_im, c_re};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // noted here so the expectation exists before any idle check looks at it
    sb.note_point(c_re, c_im, cur_limit);
  endtask

  // points biased into the box around the set so most runs go deep
  task send_random_point();
    logic signed [30:0] re, im;
    if ($urandom_range(0, 9) < 6) begin
      re = 31'(-2 * Q_ONE + int'($urandom_range(0, 671088640)));     // -2.0 .. 0.5
      im = 31'(-335544320 + int'($urandom_range(0, 671088640)));     // -1.25 .. 1.25
    end else begin
      re = 31'($urandom);
      im = 31'($urandom);
    end
    send_point(re, im);
  endtask

  // drain everything, let the unit settle, then write the limit
  task set_limit(input int unsigned value);
    @(posedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_escapes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[15:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_limit = value;
    limit_settings++;
  endtask

  initial begin
    int lim_lo[RANDOM_PHASES] = '{1, 2, 9, 33, 101, 2, 65, 300};
    int lim_hi[RANDOM_PHASES] = '{1, 8, 32, 100, 256, 64, 200, 400};
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    no_idle        = 1'b0;
    cur_limit      = mbe_pkg::LIMIT_RESET;
    limit_settings = 1;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed points under the reset limit
    send_point(0, 0);                      // origin, inside
    send_point(C_MAX, C_MAX);              // field extremes
    send_point(C_MIN, C_MIN);
    send_point(C_MAX, C_MIN);
    send_point(C_MIN, C_MAX);
    send_point(-2 * Q_ONE, 0);             // lands exactly on radius 2
    send_point(Q_QUART, 0);                // cusp, inside up to the limit
    send_point(Q_026, 0);                  // slow escape past the cusp
    send_point(Q_NECK, Q_TENTH);
    send_point(0, Q_ONE);                  // i, periodic orbit
    send_point(-Q_ONE, 0);                 // period two bulb
    send_point(1, -1);                     // tiny values, floor on negatives
    send_point(-Q_TENTH, -Q_TENTH);
    send_point(31'h2AAAAAAA, 31'h55555555);
    send_point(31'h55555555, 31'h2AAAAAAA);

    // zero limit: no step at all, inside
    set_limit(0);
    send_point(0, 0);
    send_point(C_MAX, C_MIN);

    // escape exactly on the last step still counts as inside
    set_limit(1);
    send_point(3 * Q_ONE, 0);
    send_point(-Q_ONE, Q_ONE);
    set_limit(2);
    send_point(Q_ONE, 0);                  // |z| reaches 2 on step two
    send_point(-2 * Q_ONE, 0);             // escapes after one step

    // widest limit, one long inside run
    set_limit(65535);
    send_point(0, 0);
    send_point(Q_026, 0);
    send_point(Q_NECK, Q_TENTH / 10);

    // random phases, each under its own limit
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_limit($urandom_range(lim_lo[phase], lim_hi[phase]));
      no_idle = (phase % 3 == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_random_point();
    end

    @(posedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_escapes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d points checked under %0d limit settings: %0d inside, %0d escaped",
             sb.points_seen, limit_settings, sb.inside_seen,
             sb.points_seen - sb.inside_seen);
    $display("%0d results received, %0d mismatches", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
